@@ sv/lsbr_pkg.sv @@
`default_nettype none

package lsbr_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LEN_W       = $clog2(STORE_BYTES + 1);
    localparam int TOT_W       = LEN_W + 3;

    localparam int POS_W       = 17;
    localparam int BASE_W      = POS_W - 3;
    localparam int CMP_W       = (TOT_W > POS_W) ? TOT_W : POS_W;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 7;
    localparam int ORDER_W = 2;
    localparam int VALUE_W = 64;
    localparam int BUF_W   = VALUE_W + 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_SKIP  = 3'd2,
        CMD_ALIGN = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [ORDER_W-1:0] {
        ORD_PLAIN = 2'd0,
        ORD_REV   = 2'd1,
        ORD_BE    = 2'd2
    } t_order;

    typedef struct packed {
        logic load;
        logic exec;
        logic issue;
        logic extract;
        logic respond;
    } t_ctl;

    typedef struct packed {
        logic rd_fetch;
        logic last_issue;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/lsbr_if.sv @@
`default_nettype none

interface lsbr_cmd_if;
    import lsbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [DATA_W-1:0]  data_byte;
    logic [COUNT_W-1:0] bit_count;
    logic [ORDER_W-1:0] bit_order;
    logic               peek_only;

    modport source (
        output valid, command, data_byte, bit_count, bit_order, peek_only,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, bit_count, bit_order, peek_only,
        output ready
    );
endinterface

interface lsbr_res_if;
    import lsbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               ok;

    modport source (
        output valid, value, ok,
        input  ready
    );
    modport sink (
        input  valid, value, ok,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/lsbr_ctrl.sv @@
`default_nettype none

module lsbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire lsbr_pkg::t_sts i_sts,
    output lsbr_pkg::t_ctl     o_ctl,
    output logic               o_in_ready
);
    import lsbr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_FETCH   = 6'b000100,
        S_DRAIN   = 6'b001000,
        S_EXTRACT = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = i_sts.rd_fetch ? S_FETCH : S_RESP;
            end
            S_FETCH: begin
                o_ctl.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EXTRACT;
            end
            S_EXTRACT: begin
                o_ctl.extract = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                o_ctl.respond = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ sv/lsbr_dp.sv @@
`default_nettype none

module lsbr_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lsbr_pkg::t_ctl               i_ctl,
    output lsbr_pkg::t_sts                    o_sts,
    input  wire logic [lsbr_pkg::CMD_W-1:0]   i_command,
    input  wire logic [lsbr_pkg::DATA_W-1:0]  i_data_byte,
    input  wire logic [lsbr_pkg::COUNT_W-1:0] i_bit_count,
    input  wire logic [lsbr_pkg::ORDER_W-1:0] i_bit_order,
    input  wire logic                         i_peek_only,
    input  wire logic                         i_res_ready,
    output logic                              o_res_valid,
    output logic [lsbr_pkg::VALUE_W-1:0]      o_value,
    output logic                              o_ok
);
    import lsbr_pkg::*;

    logic [DATA_W-1:0]  r_mem [STORE_BYTES];
    logic [DATA_W-1:0]  r_mem_q;

    logic [CMD_W-1:0]   r_cmd;
    logic [DATA_W-1:0]  r_data;
    logic [COUNT_W-1:0] r_cnt;
    logic [ORDER_W-1:0] r_order;
    logic               r_peek;

    logic [LEN_W-1:0]   r_len;
    logic [POS_W-1:0]   r_pos;

    logic [BASE_W-1:0]  r_base;
    logic [2:0]         r_off;
    logic [COUNT_W-1:0] r_n;
    logic [3:0]         r_nbytes;
    logic [3:0]         r_k;
    logic               r_cap_vld;
    logic [3:0]         r_cap_k;
    logic [BUF_W-1:0]   r_buf;
    logic [VALUE_W-1:0] r_ext;
    logic               r_use_val;
    logic               r_ok_res;

    logic               r_out_vld;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ok;

    logic [COUNT_W-1:0] w_n;
    logic [CMP_W-1:0]   w_total;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_avail;
    logic               w_rd_ok;
    logic               w_room;
    logic               w_push_ok;
    logic [7:0]         w_adv;
    logic               w_adv_en;
    logic [POS_W:0]     w_pos_sum;
    logic [POS_W-1:0]   w_pos_sat;
    logic [7:0]         w_span;
    logic               w_ok_now;
    logic [POS_W-1:0]   w_addr_sum;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [BUF_W-1:0]   w_shift;
    logic [VALUE_W-1:0] w_mask;
    logic [VALUE_W-1:0] w_rev_full;
    logic [VALUE_W-1:0] w_rev_v;
    logic [VALUE_W-1:0] w_swap64;
    logic [VALUE_W-1:0] w_be_v;
    logic [VALUE_W-1:0] w_final;

    assign w_n     = (r_cnt > 7'd64) ? 7'd64 : r_cnt;
    assign w_total = CMP_W'({r_len, 3'b000});
    assign w_pos   = CMP_W'(r_pos);
    assign w_avail = (w_pos < w_total) ? (w_total - w_pos) : '0;
    assign w_rd_ok = (w_avail >= CMP_W'(w_n));
    assign w_room  = (r_len < LEN_W'(STORE_BYTES));
    assign w_push_ok = i_ctl.exec && (r_cmd == CMD_PUSH) && w_room;

    always_comb begin
        w_adv    = '0;
        w_adv_en = 1'b0;
        w_ok_now = 1'b0;
        case (r_cmd)
            CMD_PUSH: begin
                w_ok_now = w_room;
            end
            CMD_READ: begin
                w_ok_now = w_rd_ok;
                w_adv_en = !r_peek;
                if (w_rd_ok || (r_order == ORD_REV)) begin
                    w_adv = 8'(w_n);
                end else begin
                    w_adv = 8'(w_avail[6:0]) + 8'd1;
                end
            end
            CMD_SKIP: begin
                w_ok_now = 1'b1;
                w_adv_en = 1'b1;
                w_adv    = 8'(r_cnt);
            end
            CMD_ALIGN: begin
                w_ok_now = 1'b1;
                w_adv_en = 1'b1;
                w_adv    = 8'(3'(3'd0 - r_pos[2:0]));
            end
            CMD_CLEAR: begin
                w_ok_now = 1'b1;
            end
            default: begin
                w_ok_now = 1'b0;
            end
        endcase
    end

    assign w_pos_sum = {1'b0, r_pos} + (POS_W+1)'(w_adv);
    assign w_pos_sat = w_pos_sum[POS_W] ? POS_MAX : w_pos_sum[POS_W-1:0];
    assign w_span    = 8'(r_pos[2:0]) + 8'(w_n) + 8'd7;

    assign o_sts.rd_fetch   = (r_cmd == CMD_READ) && w_rd_ok && (w_n != '0);
    assign o_sts.last_issue = (r_k == (r_nbytes - 4'd1));
    assign o_sts.out_free   = !r_out_vld || i_res_ready;

    assign w_addr_sum = {3'b000, r_base} + POS_W'(r_k);
    assign w_rd_addr  = ADDR_W'(w_addr_sum);

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_len[ADDR_W-1:0]] <= r_data;
        end
        if (i_ctl.issue) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pos     <= '0;
            r_cap_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_ctl.exec) begin
                if (r_cmd == CMD_CLEAR) begin
                    r_len <= '0;
                    r_pos <= '0;
                end else begin
                    if (w_push_ok) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                    if (w_adv_en) begin
                        r_pos <= w_pos_sat;
                    end
                end
            end
            r_cap_vld <= i_ctl.issue;
            if (i_ctl.respond) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        w_shift = r_buf >> r_off;
        w_mask  = (r_n == 7'd64) ? '1 : ((64'd1 << r_n) - 64'd1);
        for (int i = 0; i < VALUE_W; i++) begin
            w_rev_full[VALUE_W-1-i] = r_ext[i];
        end
        w_rev_v = w_rev_full >> (7'd64 - r_n);
        for (int b = 0; b < 8; b++) begin
            w_swap64[8*(7-b) +: 8] = r_ext[8*b +: 8];
        end
        case (r_n)
            7'd16:   w_be_v = {48'd0, r_ext[7:0], r_ext[15:8]};
            7'd32:   w_be_v = {32'd0, r_ext[7:0], r_ext[15:8], r_ext[23:16], r_ext[31:24]};
            7'd64:   w_be_v = w_swap64;
            default: w_be_v = r_ext;
        endcase
        if (!r_use_val) begin
            w_final = '0;
        end else if (r_order == ORD_REV) begin
            w_final = w_rev_v;
        end else if (r_order == ORD_BE) begin
            w_final = w_be_v;
        end else begin
            w_final = r_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_command;
            r_data  <= i_data_byte;
            r_cnt   <= i_bit_count;
            r_order <= i_bit_order;
            r_peek  <= i_peek_only;
        end
        if (i_ctl.exec) begin
            r_base    <= r_pos[POS_W-1:3];
            r_off     <= r_pos[2:0];
            r_n       <= w_n;
            r_nbytes  <= w_span[6:3];
            r_k       <= '0;
            r_buf     <= '0;
            r_use_val <= o_sts.rd_fetch;
            r_ok_res  <= w_ok_now;
        end
        if (i_ctl.issue) begin
            r_k     <= r_k + 4'd1;
            r_cap_k <= r_k;
        end
        if (r_cap_vld) begin
            r_buf[{r_cap_k, 3'b000} +: 8] <= r_mem_q;
        end
        if (i_ctl.extract) begin
            r_ext <= w_shift[VALUE_W-1:0] & w_mask;
        end
        if (i_ctl.respond) begin
            r_out_value <= w_final;
            r_out_ok    <= r_ok_res;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_value     = r_out_value;
    assign o_ok        = r_out_ok;

endmodule

`default_nettype wire

@@ sv/lsb_first_bit_reader_unit.sv @@
`default_nettype none

// Channel   Dir  Modport  Payload
// i_cmd     in   sink     command, data_byte, bit_count, bit_order, peek_only
// o_res     out  source   value, ok
//
// Push, skip, align, clear and a failed or zero-bit read go from acceptance
// through execute straight to the result. A successful read first fetches
// ceil((pos mod 8 + n) / 8) bytes, then drains and extracts: the byte store has
// one port and delivers one byte per cycle. Reset clears stored length, bit
// position and the result valid flag; store contents stay undefined. A result
// held by a stalled sink blocks only the next result, not the next acceptance.

module lsb_first_bit_reader_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lsbr_cmd_if.sink   i_cmd,
    lsbr_res_if.source o_res
);
    import lsbr_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_ready;

    lsbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_ready (w_in_ready)
    );

    lsbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_command   (i_cmd.command),
        .i_data_byte (i_cmd.data_byte),
        .i_bit_count (i_cmd.bit_count),
        .i_bit_order (i_cmd.bit_order),
        .i_peek_only (i_cmd.peek_only),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_value     (o_res.value),
        .o_ok        (o_res.ok)
    );

    assign i_cmd.ready = w_in_ready;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    import lsbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 600;
    localparam int DRAIN_CYCLES   = 30;
    localparam int RANDOM_ITEMS   = 300;
    localparam int SAT_SKIPS      = 1040;
    localparam int POS_LIM        = int'(POS_MAX);

    localparam logic [CMD_W-1:0]   CMD_UNK_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]   CMD_UNK_LAST  = 3'd7;
    localparam logic [ORDER_W-1:0] ORD_RSVD      = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [DATA_W-1:0]  data_byte;
        logic [COUNT_W-1:0] bit_count;
        logic [ORDER_W-1:0] bit_order;
        logic               peek_only;
    } t_cmd_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } t_read_res;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lsbr_cmd_if cmd_if ();
    lsbr_res_if res_if ();

    lsb_first_bit_reader_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd_item cmd_pending_q[$];
    t_read_res exp_res_q[$];

    logic [7:0] mdl_store [STORE_BYTES];
    int         mdl_len;
    int         mdl_pos;

    int n_total;
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_read_ok;
    int n_read_short;
    int n_push_dropped;
    int n_saturated;

    function automatic void add_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                                     logic [COUNT_W-1:0] count, logic [ORDER_W-1:0] order,
                                     logic peek);
        t_cmd_item it;
        it.command   = cmd;
        it.data_byte = data;
        it.bit_count = count;
        it.bit_order = order;
        it.peek_only = peek;
        cmd_pending_q.push_back(it);
        n_total++;
    endfunction

    function automatic logic [DATA_W-1:0] rnd_data();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [COUNT_W-1:0] rnd_count();
        return COUNT_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [ORDER_W-1:0] rnd_order();
        return ORDER_W'($urandom_range(0, 3));
    endfunction

    function automatic logic rnd_peek();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void pos_advance(int d);
        if (mdl_pos + d >= POS_LIM) begin
            mdl_pos = POS_LIM;
            n_saturated++;
        end else begin
            mdl_pos = mdl_pos + d;
        end
    endfunction

    function automatic t_read_res reader_predict(t_cmd_item it);
        t_read_res          r;
        int                 n;
        int                 total;
        int                 avail;
        int                 p;
        int                 nb;
        logic [ORDER_W-1:0] ord;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] w;
        r.value = '0;
        r.ok    = 1'b0;
        case (it.command)
            CMD_PUSH: begin
                if (mdl_len < STORE_BYTES) begin
                    mdl_store[mdl_len] = it.data_byte;
                    mdl_len++;
                    r.ok = 1'b1;
                end else begin
                    n_push_dropped++;
                end
            end
            CMD_READ: begin
                n     = (it.bit_count > VALUE_W) ? VALUE_W : it.bit_count;
                total = mdl_len * 8;
                avail = (mdl_pos < total) ? total - mdl_pos : 0;
                ord   = it.bit_order;
                if (ord == ORD_BE && n != 16 && n != 32 && n != 64)
                    ord = ORD_PLAIN;
                if (avail >= n) begin
                    v = '0;
                    for (int i = 0; i < n; i++) begin
                        p = mdl_pos + i;
                        if ((p >> 3) < mdl_len)
                            v[i] = mdl_store[p >> 3][p % 8];
                    end
                    w = v;
                    if (ord == ORD_REV) begin
                        w = '0;
                        for (int i = 0; i < n; i++)
                            w[n - 1 - i] = v[i];
                    end else if (ord == ORD_BE) begin
                        w  = '0;
                        nb = n / 8;
                        for (int i = 0; i < nb; i++)
                            w[8 * (nb - 1 - i) +: 8] = v[8 * i +: 8];
                    end
                    r.value = w;
                    r.ok    = 1'b1;
                    n_read_ok++;
                    if (!it.peek_only)
                        pos_advance(n);
                end else begin
                    n_read_short++;
                    if (!it.peek_only) begin
                        if (ord == ORD_REV)
                            pos_advance(n);
                        else
                            pos_advance(avail + 1);
                    end
                end
            end
            CMD_SKIP: begin
                pos_advance(it.bit_count);
                r.ok = 1'b1;
            end
            CMD_ALIGN: begin
                pos_advance((8 - mdl_pos % 8) % 8);
                r.ok = 1'b1;
            end
            CMD_CLEAR: begin
                mdl_len = 0;
                mdl_pos = 0;
                r.ok    = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic gen_directed();
        logic [7:0] seed_bytes [9] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80,
                                       8'h01, 8'hC3, 8'h3C, 8'hFF};
        add_item(CMD_READ, 8'h00, 7'd8, ORD_PLAIN, 1'b0);
        add_item(CMD_CLEAR, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        foreach (seed_bytes[i])
            add_item(CMD_PUSH, seed_bytes[i], 7'd0, ORD_PLAIN, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        add_item(CMD_ALIGN, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd3, ORD_PLAIN, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd64, ORD_REV, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd64, ORD_BE, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd32, ORD_BE, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd24, ORD_BE, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd16, ORD_BE, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd5, ORD_RSVD, 1'b0);
        add_item(CMD_ALIGN, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd100, ORD_PLAIN, 1'b1);
        add_item(CMD_READ, 8'h00, 7'd48, ORD_REV, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd1, ORD_REV, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd1, ORD_PLAIN, 1'b0);
        add_item(CMD_SKIP, 8'h00, COUNT_MAX, ORD_PLAIN, 1'b0);
        add_item(CMD_UNK_FIRST, 8'hFF, COUNT_MAX, ORD_RSVD, 1'b1);
        add_item(CMD_UNK_LAST, 8'hFF, COUNT_MAX, ORD_RSVD, 1'b1);
        add_item(CMD_CLEAR, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
    endtask

    task automatic gen_read();
        logic [COUNT_W-1:0] count;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            count = COUNT_W'(16 << $urandom_range(0, 2));
        else if (pick < 4)
            count = COUNT_W'($urandom_range(65, 127));
        else
            count = COUNT_W'($urandom_range(0, 64));
        add_item(CMD_READ, rnd_data(), count, rnd_order(), $urandom_range(0, 9) < 3);
    endtask

    task automatic gen_sequence();
        int k;
        int m;
        int r;
        if ($urandom_range(0, 1))
            add_item(CMD_CLEAR, rnd_data(), rnd_count(), rnd_order(), rnd_peek());
        k = $urandom_range(1, 24);
        repeat (k)
            add_item(CMD_PUSH, rnd_data(), rnd_count(), rnd_order(), rnd_peek());
        m = $urandom_range(2, 8);
        repeat (m) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                gen_read();
            else if (r < 80)
                add_item(CMD_SKIP, rnd_data(), COUNT_W'($urandom_range(0, 16)),
                         rnd_order(), rnd_peek());
            else if (r < 90)
                add_item(CMD_ALIGN, rnd_data(), rnd_count(), rnd_order(), rnd_peek());
            else
                add_item(CMD_PUSH, rnd_data(), rnd_count(), rnd_order(), rnd_peek());
        end
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 5))
            add_item(CMD_W'($urandom_range(0, 7)), rnd_data(), rnd_count(),
                     rnd_order(), rnd_peek());
    endtask

    task automatic gen_saturation();
        add_item(CMD_CLEAR, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        repeat (16)
            add_item(CMD_PUSH, rnd_data(), 7'd0, ORD_PLAIN, 1'b0);
        repeat (SAT_SKIPS)
            add_item(CMD_SKIP, rnd_data(), COUNT_MAX, rnd_order(), rnd_peek());
        add_item(CMD_ALIGN, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
        repeat (12) gen_read();
        add_item(CMD_READ, 8'h00, 7'd64, ORD_REV, 1'b0);
        add_item(CMD_READ, 8'h00, 7'd64, ORD_PLAIN, 1'b0);
        add_item(CMD_SKIP, 8'h00, COUNT_MAX, ORD_PLAIN, 1'b0);
        add_item(CMD_CLEAR, 8'h00, 7'd0, ORD_PLAIN, 1'b0);
    endtask

    // Driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        t_cmd_item acc;
        t_cmd_item nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                acc.command   = cmd_if.command;
                acc.data_byte = cmd_if.data_byte;
                acc.bit_count = cmd_if.bit_count;
                acc.bit_order = cmd_if.bit_order;
                acc.peek_only = cmd_if.peek_only;
                exp_res_q.push_back(reader_predict(acc));
                n_accepted++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_pending_q.size() > 0) begin
                    nxt = cmd_pending_q.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.command   <= nxt.command;
                    cmd_if.data_byte <= nxt.data_byte;
                    cmd_if.bit_count <= nxt.bit_count;
                    cmd_if.bit_order <= nxt.bit_order;
                    cmd_if.peek_only <= nxt.peek_only;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result, stall on a pattern of its own.
    t_rx_mode rx_mode;
    int       mode_left;
    int       hold_left;
    logic     hold_done;
    int       stall_tick;

    always @(posedge i_clk) begin
        t_read_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            stall_tick++;
            if (res_if.valid && res_if.ready) begin
                n_checked++;
                if (exp_res_q.size() == 0) begin
                    n_errors++;
                    $display("%0t unexpected result: value %h ok %b", $time,
                             res_if.value, res_if.ok);
                end else begin
                    want = exp_res_q.pop_front();
                    if (res_if.value !== want.value) begin
                        n_errors++;
                        $display("%0t value mismatch: expected %h actual %h", $time,
                                 want.value, res_if.value);
                    end
                    if (res_if.ok !== want.ok) begin
                        n_errors++;
                        $display("%0t ok mismatch: expected %b actual %b", $time,
                                 want.ok, res_if.ok);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:    res_if.ready <= 1'b1;
                    RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: res_if.ready <= (stall_tick % 4 != 0);
                    default:    res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d results pending",
                     $time, idle_cycles, exp_res_q.size());
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_random;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = CMD_PUSH;
        cmd_if.data_byte = '0;
        cmd_if.bit_count = '0;
        cmd_if.bit_order = ORD_PLAIN;
        cmd_if.peek_only = 1'b0;
        res_if.ready     = 1'b0;
        i_rst_n          = 1'b0;
        mdl_len          = 0;
        mdl_pos          = 0;
        burst_left       = 0;
        gap_left         = 0;
        mode_left        = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        stall_tick       = 0;
        rx_mode          = RX_OPEN;

        gen_directed();
        n_random = n_total;
        while (n_total - n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85)
                gen_sequence();
            else
                gen_noise();
        end
        gen_saturation();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge i_clk);
        while (exp_res_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d commands, %0d reads ok, %0d short reads, %0d pushes dropped",
                 n_accepted, n_read_ok, n_read_short, n_push_dropped);
        $display("tb: %0d results checked, %0d saturating advances, %0d mismatches",
                 n_checked, n_saturated, n_errors);
        if (n_errors == 0 && exp_res_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/lsbr_pkg.sv
sv/lsbr_if.sv
sv/lsbr_ctrl.sv
sv/lsbr_dp.sv
sv/lsb_first_bit_reader_unit.sv
tb/tb.sv
